// ----- hw/rtl/tickless_software_timer_bank_core_assert.svh -----
// Assertion macros used by the timer bank core.
`ifndef TICKLESS_SOFTWARE_TIMER_BANK_CORE_ASSERT_SVH
`define TICKLESS_SOFTWARE_TIMER_BANK_CORE_ASSERT_SVH
// Assert that a condition implies a consequence in the same cycle.
`define TSTB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle.
`define TSTB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- hw/rtl/tstb_pkg.sv -----
// ----------------------------------------------------------------------------
// Timer bank package
// Action codes, controller states and the cell control bundle.
// ----------------------------------------------------------------------------
package tstb_pkg;

  localparam logic [1:0] ActStart = 2'd0;
  localparam logic [1:0] ActStop  = 2'd1;
  localparam logic [1:0] ActTick  = 2'd2;

  typedef enum logic [1:0] {
    StIdle,
    StWalk,
    StReport
  } state_e;

  // Control broadcast from the controller to every cell.
  typedef struct packed {
    logic start;   // load the addressed cell
    logic stop;    // clear the addressed cell
    logic shift;   // rotate the ring by one cell
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/tstb_if.sv -----
// ----------------------------------------------------------------------------
// Timer bank channels
// Valid/ready interfaces for the request and report channels.
// ----------------------------------------------------------------------------
interface tstb_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [3:0]  slot;
  logic [31:0] interval;
  logic [31:0] tolerance;
  logic        one_shot;
  modport source (output valid, action, slot, interval, tolerance, one_shot, input ready);
  modport sink   (input valid, action, slot, interval, tolerance, one_shot, output ready);
endinterface

interface tstb_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  expired_slot;
  logic        last;
  logic [31:0] next_period;
  modport source (output valid, expired_slot, last, next_period, input ready);
  modport sink   (input valid, expired_slot, last, next_period, output ready);
endinterface

// ----- hw/rtl/tstb_cell.sv -----
// ----------------------------------------------------------------------------
// Timer bank cell
// Holds one slot; the ring of cells rotates by one cell per walk step.
// ----------------------------------------------------------------------------
module tstb_cell
  import tstb_pkg::*;
#(
  parameter int TW = 32,
  parameter int SW = 4,
  parameter logic [SW-1:0] ID = '0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cell_ctrl_t    ctrl_i,
  input  logic          sel_i,
  input  logic [TW-1:0] ival_i,
  input  logic [TW-1:0] tol_i,
  input  logic          single_i,
  // Neighbor input (for the tail cell, the head values as updated by the walk).
  input  logic          act_i,
  input  logic          sgl_i,
  input  logic [TW-1:0] nival_i,
  input  logic [TW-1:0] ntol_i,
  input  logic [TW-1:0] nleft_i,
  input  logic [SW-1:0] nid_i,
  output logic          act_o,
  output logic          sgl_o,
  output logic [TW-1:0] ival_o,
  output logic [TW-1:0] tol_o,
  output logic [TW-1:0] left_o,
  output logic [SW-1:0] id_o
);

  logic          act_q, sgl_q;
  logic [TW-1:0] ival_q, tol_q, left_q;
  logic [SW-1:0] id_q;

  // Control bits: id resets to the cell's home place in the ring.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      sgl_q <= 1'b0;
      id_q  <= ID;
    end else if (ctrl_i.shift) begin
      act_q <= act_i;
      sgl_q <= sgl_i;
      id_q  <= nid_i;
    end else if (sel_i && ctrl_i.start) begin
      act_q <= 1'b1;
      sgl_q <= single_i;
    end else if (sel_i && ctrl_i.stop) begin
      act_q <= 1'b0;
      sgl_q <= 1'b0;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      ival_q <= nival_i;
      tol_q  <= ntol_i;
      left_q <= nleft_i;
    end else if (sel_i && ctrl_i.start) begin
      ival_q <= ival_i;
      tol_q  <= tol_i;
      left_q <= ival_i;
    end
  end

  assign act_o  = act_q;
  assign sgl_o  = sgl_q;
  assign ival_o = ival_q;
  assign tol_o  = tol_q;
  assign left_o = left_q;
  assign id_o   = id_q;

endmodule

// ----- hw/rtl/tickless_software_timer_bank_core.sv -----
// ----------------------------------------------------------------------------
// Tickless software timer bank core
// A ring of timer cells with one shared wakeup countdown.
// ----------------------------------------------------------------------------
// Usage: req_if carries start, stop and tick beats; rsp_if carries one beat
// per expired slot of a wakeup, in ascending slot order, the final one with
// last set. Start, stop and ticks that do not reach zero need no walk.
// A wakeup rotates the ring of NUM_TIMERS cells once, one cell per cycle,
// through the single update unit at the ring head. Reports are held in a
// small queue of at most sixteen entries and drained one per cycle while
// the receiver is ready; a stalled receiver holds the report and the block
// takes no new beat until the queue is empty. Reset clears all active
// flags and stops the countdown. Slot index follows each cell around the
// ring, so the ring returns to its home order after a full turn.
// ----------------------------------------------------------------------------
module tickless_software_timer_bank_core
  import tstb_pkg::*;
#(
  parameter int NUM_TIMERS = 16,
  parameter int TICK_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  tstb_req_if.sink   req_if,
  tstb_rsp_if.source rsp_if
);

  localparam int TW = TICK_WIDTH;
  localparam int SW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW = $clog2(NUM_TIMERS + 1);
  localparam logic [TW-1:0] Ones = '1;

  state_e        state_q, state_d;
  cell_ctrl_t    ctrl;
  logic [TW-1:0] plen_q, plen_d, cnt_q, cnt_d, next_q, next_d;
  logic          run_q, run_d;
  logic [CW-1:0] step_q, step_d;
  logic [3:0]    hit_slot_q [16];
  logic [4:0]    nhit_q, nhit_d, rd_q, rd_d;
  logic          push;

  logic          act [NUM_TIMERS];
  logic          sgl [NUM_TIMERS];
  logic [TW-1:0] ival [NUM_TIMERS];
  logic [TW-1:0] tol [NUM_TIMERS];
  logic [TW-1:0] left [NUM_TIMERS];
  logic [SW-1:0] id [NUM_TIMERS];

  // Ring head update values.
  logic          h_act, h_sgl, h_exp;
  logic [TW-1:0] h_left, h_offer;
  logic [TW:0]   sum;
  logic [TW-1:0] in_ival, in_tol;
  logic          any_other;

  assign in_ival = TW'(req_if.interval);
  assign in_tol  = TW'(req_if.tolerance);

  // Head cell (index 0) is evaluated and re-enters at the ring tail.
  always_comb begin
    sum     = {1'b0, ival[0]} + {1'b0, tol[0]};
    h_exp   = act[0] && (left[0] <= plen_q);
    h_act   = act[0] && !(h_exp && sgl[0]);
    h_sgl   = h_act ? sgl[0] : 1'b0;
    h_left  = h_exp ? ival[0] : left[0] - plen_q;
    h_offer = Ones;
    if (act[0]) begin
      if (h_exp) begin
        if (!sgl[0]) h_offer = sum[TW] ? Ones : sum[TW-1:0];
      end else begin
        h_offer = h_left;
      end
    end
  end

  // Active cells other than the stopped one.
  always_comb begin
    any_other = 1'b0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (act[i] && !(id[i] == SW'(req_if.slot))) any_other = 1'b1;
    end
  end

  genvar g;
  generate
    for (g = 0; g < NUM_TIMERS; g++) begin : g_cell
      localparam int N = (g + 1) % NUM_TIMERS;
      logic          n_act, n_sgl;
      logic [TW-1:0] n_ival, n_tol, n_left;
      logic [SW-1:0] n_id;
      if (g == NUM_TIMERS - 1) begin : g_tail
        assign n_act  = h_act;
        assign n_sgl  = h_sgl;
        assign n_ival = ival[0];
        assign n_tol  = tol[0];
        assign n_left = h_left;
        assign n_id   = id[0];
      end else begin : g_mid
        assign n_act  = act[N];
        assign n_sgl  = sgl[N];
        assign n_ival = ival[N];
        assign n_tol  = tol[N];
        assign n_left = left[N];
        assign n_id   = id[N];
      end
      tstb_cell #(.TW(TW), .SW(SW), .ID(SW'(g))) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl),
        .sel_i   (id[g] == SW'(req_if.slot)),
        .ival_i  (in_ival),
        .tol_i   (in_tol),
        .single_i(req_if.one_shot),
        .act_i   (n_act),
        .sgl_i   (n_sgl),
        .nival_i (n_ival),
        .ntol_i  (n_tol),
        .nleft_i (n_left),
        .nid_i   (n_id),
        .act_o   (act[g]),
        .sgl_o   (sgl[g]),
        .ival_o  (ival[g]),
        .tol_o   (tol[g]),
        .left_o  (left[g]),
        .id_o    (id[g])
      );
    end
  endgenerate

  logic slot_ok;
  assign slot_ok = 32'(req_if.slot) < NUM_TIMERS;

  // Controller.
  always_comb begin
    state_d = state_q;
    plen_d  = plen_q;
    cnt_d   = cnt_q;
    run_d   = run_q;
    next_d  = next_q;
    step_d  = step_q;
    nhit_d  = nhit_q;
    rd_d    = rd_q;
    ctrl    = '0;
    push    = 1'b0;
    req_if.ready = (state_q == StIdle);
    case (state_q)
      StIdle: begin
        if (req_if.valid) begin
          case (req_if.action)
            ActStart: if (slot_ok) begin
              ctrl.start = 1'b1;
              if (!run_q) begin
                plen_d = in_ival;
                cnt_d  = in_ival;
                run_d  = 1'b1;
              end else if (cnt_q > in_ival) begin
                plen_d = (plen_q >= cnt_q - in_ival) ? plen_q - (cnt_q - in_ival) : '0;
                cnt_d  = in_ival;
              end
            end
            ActStop: if (slot_ok) begin
              ctrl.stop = 1'b1;
              if (!any_other) run_d = 1'b0;
            end
            ActTick: if (run_q) begin
              if (cnt_q > TW'(1)) cnt_d = cnt_q - 1'b1;
              else begin
                cnt_d   = '0;
                next_d  = Ones;
                step_d  = '0;
                nhit_d  = '0;
                state_d = StWalk;
              end
            end
            default: ;
          endcase
        end
      end
      StWalk: begin
        ctrl.shift = 1'b1;
        if (h_offer < next_q) next_d = h_offer;
        if (h_exp && nhit_q < 5'd16) begin
          push   = 1'b1;
          nhit_d = nhit_q + 1'b1;
        end
        step_d = step_q + 1'b1;
        if (step_q == CW'(NUM_TIMERS - 1)) begin
          plen_d = next_d;
          cnt_d  = next_d;
          if (next_d == Ones) run_d = 1'b0;
          rd_d = '0;
          state_d = (nhit_d == '0) ? StIdle : StReport;
        end
      end
      StReport: begin
        if (rsp_if.ready) begin
          rd_d = rd_q + 1'b1;
          if (rd_q + 1'b1 == nhit_q) state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      plen_q  <= '0;
      cnt_q   <= '0;
      run_q   <= 1'b0;
      next_q  <= '0;
      step_q  <= '0;
      nhit_q  <= '0;
      rd_q    <= '0;
    end else begin
      state_q <= state_d;
      plen_q  <= plen_d;
      cnt_q   <= cnt_d;
      run_q   <= run_d;
      next_q  <= next_d;
      step_q  <= step_d;
      nhit_q  <= nhit_d;
      rd_q    <= rd_d;
    end
  end

  // Report queue.
  always_ff @(posedge clk_i) begin
    if (push) hit_slot_q[nhit_q[3:0]] <= 4'(id[0]);
  end

  assign rsp_if.valid        = (state_q == StReport);
  assign rsp_if.expired_slot = hit_slot_q[rd_q[3:0]];
  assign rsp_if.last         = (rd_q + 1'b1 == nhit_q);
  assign rsp_if.next_period  = 32'(plen_q);

  `include "tickless_software_timer_bank_core_assert.svh"

  `TSTB_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, req_if.ready, state_q == StIdle)
  `TSTB_ASSERT_IMP(a_report_cnt, clk_i, rst_ni, state_q == StReport, rd_q < nhit_q)
  `TSTB_ASSERT_IMP(a_hits_max, clk_i, rst_ni, 1'b1, nhit_q <= 5'd16)
  `TSTB_ASSERT_NEXT(a_walk_ends, clk_i, rst_ni,
    state_q == StWalk && step_q == CW'(NUM_TIMERS - 1), state_q != StWalk)

endmodule

// ----- test/tstb_test_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer bank test channels
// Note: the channel interfaces themselves come from the RTL file list; this
// file only holds the shared beat types used by the testbench.
// ----------------------------------------------------------------------------
package tstb_test_pkg;

  // One expected expiry report.
  typedef struct packed {
    logic [3:0]  expired_slot;
    logic        last;
    logic [31:0] next_period;
  } expiry_t;

endpackage

// ----- test/tstb_expiry_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer bank expiry checker
// Watches request and report beats, predicts the expiry reports of every
// wakeup and compares them in order against the observed reports.
// ----------------------------------------------------------------------------
module tstb_expiry_checker
  import tstb_pkg::*;
  import tstb_test_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [1:0]  req_action_i,
  input  logic [3:0]  req_slot_i,
  input  logic [31:0] req_interval_i,
  input  logic [31:0] req_tolerance_i,
  input  logic        req_one_shot_i,
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  logic [3:0]  rsp_expired_slot_i,
  input  logic        rsp_last_i,
  input  logic [31:0] rsp_next_period_i,
  output int          errors_o,
  output int          pending_o,
  output int          reports_o,
  output int          wakeups_o
);

  localparam logic [31:0] AllOnes = 32'hffff_ffff;

  logic [31:0] interval_q [16];
  logic [31:0] left_q     [16];
  logic [31:0] tol_q      [16];
  logic [15:0] active_q;
  logic [15:0] single_q;
  logic [31:0] length_q;
  logic [31:0] count_q;
  logic        running_q;
  expiry_t     expected_q[$];

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? AllOnes : s[31:0];
  endfunction

  // Rotate all active slots by one period and queue their expiry reports.
  task automatic run_wakeup();
    logic [31:0] best;
    logic [3:0]  hit[$];
    best = AllOnes;
    for (int i = 0; i < 16; i++) begin
      if (active_q[i]) begin
        if (left_q[i] <= length_q) begin
          hit.push_back(i[3:0]);
          if (single_q[i]) begin
            active_q[i] = 1'b0;
          end else begin
            left_q[i] = interval_q[i];
            if (sat_sum(interval_q[i], tol_q[i]) < best) best = sat_sum(interval_q[i], tol_q[i]);
          end
        end else begin
          left_q[i] = left_q[i] - length_q;
          if (left_q[i] < best) best = left_q[i];
        end
      end
    end
    length_q = best;
    count_q  = best;
    if (best == AllOnes) running_q = 1'b0;
    if (hit.size() > 0) wakeups_o++;
    foreach (hit[k]) expected_q.push_back({hit[k], k == hit.size() - 1, best});
  endtask

  task automatic apply_request();
    logic [31:0] d;
    case (req_action_i)
      ActStart: begin
        interval_q[req_slot_i] = req_interval_i;
        tol_q[req_slot_i]      = req_tolerance_i;
        single_q[req_slot_i]   = req_one_shot_i;
        left_q[req_slot_i]     = req_interval_i;
        active_q[req_slot_i]   = 1'b1;
        if (!running_q) begin
          length_q  = req_interval_i;
          count_q   = req_interval_i;
          running_q = 1'b1;
        end else if (count_q > req_interval_i) begin
          d = count_q - req_interval_i;
          length_q = (length_q >= d) ? length_q - d : '0;
          count_q  = req_interval_i;
        end
      end
      ActStop: begin
        active_q[req_slot_i] = 1'b0;
        single_q[req_slot_i] = 1'b0;
        if (active_q == '0) running_q = 1'b0;
      end
      ActTick: begin
        if (running_q) begin
          if (count_q > 0) count_q--;
          if (count_q == 0) run_wakeup();
        end
      end
      default: ;
    endcase
  endtask

  // Both channels are sampled on the edge; requests first, so a report that
  // a request causes is always queued before it can be seen.
  always @(posedge clk_i or negedge rst_ni) begin
    expiry_t want;
    if (!rst_ni) begin
      active_q  <= '0;
      single_q  <= '0;
      length_q  <= '0;
      count_q   <= '0;
      running_q <= 1'b0;
      expected_q.delete();
      errors_o  <= 0;
      reports_o <= 0;
      wakeups_o <= 0;
    end else begin
      if (req_valid_i && req_ready_i) apply_request();
      if (rsp_valid_i && rsp_ready_i) begin
        reports_o++;
        if (expected_q.size() == 0) begin
          $error("unexpected report for slot %0d", rsp_expired_slot_i);
          errors_o++;
        end else begin
          want = expected_q.pop_front();
          if (rsp_expired_slot_i !== want.expired_slot) begin
            $error("expired_slot: expected %0d, got %0d", want.expired_slot,
                   rsp_expired_slot_i);
            errors_o++;
          end
          if (rsp_last_i !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, rsp_last_i);
            errors_o++;
          end
          if (rsp_next_period_i !== want.next_period) begin
            $error("next_period: expected %0h, got %0h", want.next_period,
                   rsp_next_period_i);
            errors_o++;
          end
        end
      end
    end
  end

  assign pending_o = expected_q.size();

endmodule

// ----- test/tickless_software_timer_bank_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer bank testbench
// Drives start, stop, tick and unused beats with random gaps and a randomly
// stalled report receiver; a separate checker predicts and compares the reports.
// ----------------------------------------------------------------------------
module tickless_software_timer_bank_core_test;
  import tstb_pkg::*;

  localparam int CycleLimit = 1_000_000;
  localparam logic [1:0] ActUnused = 2'd3;

  logic clk_i;
  logic rst_ni;
  int   cycles;
  int   errors;
  int   pending;
  int   reports;
  int   wakeups;
  int   sent;

  tstb_req_if req_if ();
  tstb_rsp_if rsp_if ();

  tickless_software_timer_bank_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_if (req_if),
    .rsp_if (rsp_if)
  );

  tstb_expiry_checker checker_i (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .req_valid_i        (req_if.valid),
    .req_ready_i        (req_if.ready),
    .req_action_i       (req_if.action),
    .req_slot_i         (req_if.slot),
    .req_interval_i     (req_if.interval),
    .req_tolerance_i    (req_if.tolerance),
    .req_one_shot_i     (req_if.one_shot),
    .rsp_valid_i        (rsp_if.valid),
    .rsp_ready_i        (rsp_if.ready),
    .rsp_expired_slot_i (rsp_if.expired_slot),
    .rsp_last_i         (rsp_if.last),
    .rsp_next_period_i  (rsp_if.next_period),
    .errors_o           (errors),
    .pending_o          (pending),
    .reports_o          (reports),
    .wakeups_o          (wakeups)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tickless_software_timer_bank_core verification failed");
      $finish;
    end
  end

  // Report receiver: random stall before each beat, with stall-free stretches.
  initial begin
    int stall;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      repeat (stall) @(posedge clk_i);
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      rsp_if.ready <= 1'b0;
    end
  end

  // Send one beat after a random gap and wait for its acceptance.
  task automatic send_beat(logic [1:0] act, logic [3:0] slt, logic [31:0] ival,
                           logic [31:0] tol, logic single, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.action    <= act;
    req_if.slot      <= slt;
    req_if.interval  <= ival;
    req_if.tolerance <= tol;
    req_if.one_shot  <= single;
    do @(posedge clk_i); while (!req_if.ready);
    sent++;
  endtask

  task automatic tick_burst(int n, bit gaps);
    repeat (n) send_beat(ActTick, 4'($urandom), $urandom, $urandom, 1'($urandom), gaps);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    logic [31:0] ival;
    int          pick;
    cycles  = 0;
    sent    = 0;
    rst_ni  = 1'b0;
    req_if.valid     = 1'b0;
    req_if.action    = ActTick;
    req_if.slot      = '0;
    req_if.interval  = '0;
    req_if.tolerance = '0;
    req_if.one_shot  = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: ticks while stopped, unused action, extremes of the fields.
    tick_burst(2, 1'b0);
    send_beat(ActUnused, 4'hf, '1, '1, 1'b1, 1'b0);
    send_beat(ActStart, 4'd0, 32'd1, 32'd0, 1'b1, 1'b0);
    send_beat(ActStart, 4'd15, 32'd3, 32'hffff_ffff, 1'b0, 1'b0);
    send_beat(ActStart, 4'd7, 32'hffff_ffff, 32'd5, 1'b0, 1'b0);
    tick_burst(4, 1'b0);
    send_beat(ActStart, 4'd15, 32'd2, 32'd0, 1'b0, 1'b0);  // restart of an active slot
    tick_burst(5, 1'b1);
    send_beat(ActStop, 4'd15, '0, '0, 1'b0, 1'b0);
    send_beat(ActStop, 4'd7, '0, '0, 1'b0, 1'b0);          // last active slot stops
    send_beat(ActStop, 4'd3, '0, '0, 1'b0, 1'b0);          // stop of an idle slot
    tick_burst(1, 1'b0);
    // All sixteen slots expiring in the same wakeup.
    for (int i = 0; i < 16; i++) send_beat(ActStart, i[3:0], 32'd2, 32'd1, i[0], 1'b1);
    tick_burst(3, 1'b0);
    drain();

    // Random: mostly short intervals with enough ticks to expire them.
    while (sent < 380) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        ival = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(1, 12);
        send_beat(ActStart, 4'($urandom), ival,
                  ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 4),
                  1'($urandom), 1'b1);
      end else if (pick < 40) begin
        send_beat(ActStop, 4'($urandom), $urandom, $urandom, 1'($urandom), 1'b1);
      end else if (pick < 42) begin
        send_beat(ActUnused, 4'($urandom), $urandom, $urandom, 1'($urandom), 1'b1);
      end else begin
        tick_burst($urandom_range(1, 6), $urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 49) == 0) drain();
    end

    drain();
    repeat (60) @(posedge clk_i);
    $display("Sent %0d request beats; checked %0d expiry reports over %0d wakeups.",
             sent, reports, wakeups);
    if (errors == 0 && pending == 0) begin
      $display("tickless_software_timer_bank_core verification clean");
    end else begin
      $display("tickless_software_timer_bank_core verification failed");
    end
    $finish;
  end

endmodule
